### sv/frm_pkg.sv
// Package for fraction_reduce_and_max: default width, datapath commands and status, controller states.
`default_nettype none
package frm_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 32;

    // Datapath commands issued by the controller
    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_GCD_STEP,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_MUL_INIT,
        CMD_MUL_STEP,
        CMD_FINISH
    } cmd_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GCD,
        ST_DIV_INIT,
        ST_DIV,
        ST_NEXT,
        ST_MUL,
        ST_FINISH,
        ST_OUT
    } state_t;

    // Status reported by the datapath
    typedef struct packed {
        logic gcd_done;
        logic div_done;
        logic mul_done;
        logic zero_den;
    } status_t;

    // Command bundle sent to the datapath
    typedef struct packed {
        cmd_t cmd;
        logic sel;
    } ctrl_t;

endpackage
`default_nettype wire

### sv/frm_datapath.sv
// Datapath for fraction reduction: binary GCD, restoring divider, shift-add multiplier.
`default_nettype none
module frm_datapath #(
    parameter int unsigned VALUE_WIDTH = frm_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire frm_pkg::ctrl_t                ctrl,
    output frm_pkg::status_t                   status,
    input  wire logic signed [VALUE_WIDTH-1:0] num_first,
    input  wire logic signed [VALUE_WIDTH-1:0] den_first,
    input  wire logic signed [VALUE_WIDTH-1:0] num_second,
    input  wire logic signed [VALUE_WIDTH-1:0] den_second,
    output logic signed [VALUE_WIDTH-1:0]      max_num,
    output logic [VALUE_WIDTH-2:0]             max_den,
    output logic                               second_chosen,
    output logic                               zero_den_error
);
    localparam int unsigned W  = VALUE_WIDTH;
    localparam int unsigned W2 = 2 * VALUE_WIDTH;
    localparam int unsigned CW = $clog2(W2 + 1);
    localparam int unsigned SW = $clog2(W + 1);
    localparam logic [W-1:0] LIM = {1'b0, {(W-1){1'b1}}};

    // Magnitudes (W bits hold 2^(W-1)) and signs of both fractions
    logic [W-1:0] mn_reg [2];
    logic [W-1:0] mn_next [2];
    logic [W-1:0] md_reg [2];
    logic [W-1:0] md_next [2];
    logic         neg_reg [2];
    logic         neg_next [2];
    // GCD registers
    logic [W-1:0] ga_reg, ga_next, gb_reg, gb_next;
    logic [SW-1:0] gk_reg, gk_next;
    logic [W-1:0] g_reg, g_next;
    // Divider
    logic [W-1:0] q_reg, q_next, r_reg, r_next, dv_reg, dv_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic         dpart_reg, dpart_next;
    // Multiplier: a * b accumulated, two products
    logic [W2-1:0] acc_reg, acc_next, mc_reg, mc_next;
    logic [W-1:0]  mp_reg, mp_next;
    logic [W2-1:0] p1_reg, p1_next;
    logic          mph_reg, mph_next;
    logic          zero_reg, zero_next;
    logic signed [W-1:0] on_reg, on_next;
    logic [W-2:0]  od_reg, od_next;
    logic          sc_reg, sc_next;

    logic [W:0]    rtrial;
    logic          ge;
    logic [W-1:0]  gdiff;
    logic          s1, s2, sec;
    logic [W-1:0]  rnm, rdm;
    logic          rng;

    function automatic logic [W-1:0] absv(input logic [W-1:0] v);
        absv = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    assign status.gcd_done = (gb_reg == '0);
    assign status.div_done = (cnt_reg == '0);
    assign status.mul_done = (cnt_reg == '0);
    assign status.zero_den = zero_reg;

    assign rtrial = {r_reg, q_reg[W-1]} - {1'b0, dv_reg};
    assign gdiff  = (ga_reg > gb_reg) ? ga_reg - gb_reg : gb_reg - ga_reg;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            mn_next[i]  = mn_reg[i];
            md_next[i]  = md_reg[i];
            neg_next[i] = neg_reg[i];
        end
        ga_next = ga_reg; gb_next = gb_reg; gk_next = gk_reg; g_next = g_reg;
        q_next = q_reg; r_next = r_reg; dv_next = dv_reg; cnt_next = cnt_reg;
        dpart_next = dpart_reg;
        acc_next = acc_reg; mc_next = mc_reg; mp_next = mp_reg; p1_next = p1_reg;
        mph_next = mph_reg; zero_next = zero_reg;
        on_next = on_reg; od_next = od_reg; sc_next = sc_reg;
        s1 = 1'b0; s2 = 1'b0; sec = 1'b0; rnm = '0; rdm = '0; rng = 1'b0; ge = 1'b0;
        unique case (ctrl.cmd)
            frm_pkg::CMD_LOAD:
            begin
                // Capture magnitudes and signs; sign goes to the numerator
                mn_next[0]  = absv(num_first);
                md_next[0]  = absv(den_first);
                neg_next[0] = (num_first[W-1] ^ den_first[W-1]) && (num_first != '0);
                mn_next[1]  = absv(num_second);
                md_next[1]  = absv(den_second);
                neg_next[1] = (num_second[W-1] ^ den_second[W-1]) && (num_second != '0);
                zero_next   = (den_first == '0) || (den_second == '0);
                ga_next = absv(num_first);
                gb_next = absv(den_first);
                gk_next = '0;
                dpart_next = 1'b0;
            end
            frm_pkg::CMD_GCD_STEP:
            begin
                // One binary GCD step; gb reaches zero when done
                if (ga_reg == '0)
                begin
                    ga_next = gb_reg;
                    gb_next = '0;
                end
                else if (gb_reg == '0)
                begin
                    gb_next = '0;
                end
                else if (!ga_reg[0] && !gb_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    gk_next = gk_reg + 1'b1;
                end
                else if (!ga_reg[0])
                    ga_next = ga_reg >> 1;
                else if (!gb_reg[0])
                    gb_next = gb_reg >> 1;
                else
                begin
                    ga_next = (ga_reg < gb_reg) ? ga_reg : gb_reg;
                    gb_next = gdiff;
                end
                if (gb_next == '0)
                    g_next = ga_next << gk_next;
            end
            frm_pkg::CMD_DIV_INIT:
            begin
                // Divide numerator (part 0) or denominator (part 1) by the GCD
                q_next  = dpart_reg ? md_reg[ctrl.sel] : mn_reg[ctrl.sel];
                r_next  = '0;
                dv_next = g_reg;
                cnt_next = CW'(W);
            end
            frm_pkg::CMD_DIV_STEP:
            begin
                ge = !rtrial[W];
                r_next = ge ? rtrial[W-1:0] : {r_reg[W-2:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    if (dpart_reg)
                        md_next[ctrl.sel] = {q_reg[W-2:0], ge};
                    else
                        mn_next[ctrl.sel] = {q_reg[W-2:0], ge};
                    dpart_next = !dpart_reg;
                    if (dpart_reg && !ctrl.sel)
                    begin
                        ga_next = mn_reg[1];
                        gb_next = md_reg[1];
                        gk_next = '0;
                    end
                end
            end
            frm_pkg::CMD_MUL_INIT:
            begin
                // Start first cross-product |n1|*d2
                acc_next = '0;
                mc_next  = W2'(mn_reg[0]);
                mp_next  = md_reg[1];
                cnt_next = CW'(W);
                mph_next = 1'b0;
            end
            frm_pkg::CMD_MUL_STEP:
            begin
                // Shift-add: one multiplier bit per cycle, two products in turn
                if (mp_reg[0])
                    acc_next = acc_reg + mc_reg;
                mc_next  = mc_reg << 1;
                mp_next  = mp_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1) && !mph_reg)
                begin
                    p1_next  = acc_next;
                    acc_next = '0;
                    mc_next  = W2'(mn_reg[1]);
                    mp_next  = md_reg[0];
                    cnt_next = CW'(W);
                    mph_next = 1'b1;
                end
            end
            frm_pkg::CMD_FINISH:
            begin
                // Compare signed cross-products and saturate the winner
                s1 = neg_reg[0] && (p1_reg != '0);
                s2 = neg_reg[1] && (acc_reg != '0);
                if (s1 != s2)
                    sec = s1;
                else if (s1)
                    sec = acc_reg < p1_reg;
                else
                    sec = acc_reg > p1_reg;
                rnm = sec ? mn_reg[1] : mn_reg[0];
                rdm = sec ? md_reg[1] : md_reg[0];
                rng = sec ? neg_reg[1] : neg_reg[0];
                if (rnm > LIM)
                    rnm = LIM;
                if (rdm > LIM)
                    rdm = LIM;
                if (zero_reg)
                begin
                    on_next = '0; od_next = '0; sc_next = 1'b0;
                end
                else
                begin
                    on_next = rng ? -$signed(rnm) : $signed(rnm);
                    od_next = rdm[W-2:0];
                    sc_next = sec;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            mn_reg[i]  <= mn_next[i];
            md_reg[i]  <= md_next[i];
            neg_reg[i] <= neg_next[i];
        end
        ga_reg <= ga_next; gb_reg <= gb_next; gk_reg <= gk_next; g_reg <= g_next;
        q_reg <= q_next; r_reg <= r_next; dv_reg <= dv_next; cnt_reg <= cnt_next;
        dpart_reg <= dpart_next;
        acc_reg <= acc_next; mc_reg <= mc_next; mp_reg <= mp_next; p1_reg <= p1_next;
        mph_reg <= mph_next; zero_reg <= zero_next;
        on_reg <= on_next; od_reg <= od_next; sc_reg <= sc_next;
    end

    assign max_num        = on_reg;
    assign max_den        = od_reg;
    assign second_chosen  = sc_reg;
    assign zero_den_error = zero_reg;
endmodule
`default_nettype wire

### sv/frm_ctrl.sv
// Controller state machine sequencing GCD, division and multiplication.
`default_nettype none
module frm_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire frm_pkg::status_t status,
    output frm_pkg::ctrl_t        ctrl
);
    frm_pkg::state_t state_reg, state_next;
    logic sel_reg, sel_next, part_reg, part_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= frm_pkg::ST_IDLE;
            sel_reg   <= 1'b0;
            part_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            part_reg  <= part_next;
        end
    end

    // Advance through the phases of one item
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        part_next  = part_reg;
        ctrl.cmd   = frm_pkg::CMD_IDLE;
        ctrl.sel   = sel_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            frm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.cmd   = frm_pkg::CMD_LOAD;
                    state_next = frm_pkg::ST_LOAD;
                end
            end
            frm_pkg::ST_LOAD:
            begin
                sel_next   = 1'b0;
                part_next  = 1'b0;
                state_next = status.zero_den ? frm_pkg::ST_FINISH : frm_pkg::ST_GCD;
            end
            frm_pkg::ST_GCD:
            begin
                if (status.gcd_done)
                    state_next = frm_pkg::ST_DIV_INIT;
                else
                    ctrl.cmd = frm_pkg::CMD_GCD_STEP;
            end
            frm_pkg::ST_DIV_INIT:
            begin
                ctrl.cmd   = frm_pkg::CMD_DIV_INIT;
                state_next = frm_pkg::ST_DIV;
            end
            frm_pkg::ST_DIV:
            begin
                ctrl.cmd = frm_pkg::CMD_DIV_STEP;
                if (status.div_done)
                begin
                    ctrl.cmd   = frm_pkg::CMD_IDLE;
                    state_next = frm_pkg::ST_NEXT;
                end
            end
            frm_pkg::ST_NEXT:
            begin
                // Choose the next division or move on
                part_next = !part_reg;
                if (!part_reg)
                    state_next = frm_pkg::ST_DIV_INIT;
                else if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = frm_pkg::ST_GCD;
                end
                else
                begin
                    ctrl.cmd   = frm_pkg::CMD_MUL_INIT;
                    state_next = frm_pkg::ST_MUL;
                end
            end
            frm_pkg::ST_MUL:
            begin
                ctrl.cmd = frm_pkg::CMD_MUL_STEP;
                if (status.mul_done)
                begin
                    ctrl.cmd   = frm_pkg::CMD_IDLE;
                    state_next = frm_pkg::ST_FINISH;
                end
            end
            frm_pkg::ST_FINISH:
            begin
                ctrl.cmd   = frm_pkg::CMD_FINISH;
                state_next = frm_pkg::ST_OUT;
            end
            frm_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = frm_pkg::ST_IDLE;
            end
            default:
                state_next = frm_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### sv/fraction_reduce_and_max.sv
// Top level of fraction_reduce_and_max: controller, datapath and checks.
// Usage:
//   Input channel (in_valid/in_ready) carries two signed fractions; output
//   channel (out_valid/out_ready) returns the larger reduced fraction, a flag
//   for the second being strictly larger, and a zero-denominator error flag.
//   One item is processed at a time. Each fraction takes a binary GCD plus
//   two restoring divisions; the comparison runs two shift-add
//   multiplications. The number of GCD steps depends on the operands; the
//   shared divider and multiplier step one bit per cycle.
//   A zero denominator skips the arithmetic and goes straight to the result.
//   Reset returns the controller to idle, ready for an item; no result pends.
//   The result stays held while the receiver stalls; no new item is taken
//   until it is delivered, and the next item can be accepted in the cycle after.
`default_nettype none
module fraction_reduce_and_max #(
    parameter int unsigned VALUE_WIDTH = frm_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [VALUE_WIDTH-1:0] num_first,
    input  wire logic signed [VALUE_WIDTH-1:0] den_first,
    input  wire logic signed [VALUE_WIDTH-1:0] num_second,
    input  wire logic signed [VALUE_WIDTH-1:0] den_second,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [VALUE_WIDTH-1:0]      max_num,
    output logic [VALUE_WIDTH-2:0]             max_den,
    output logic                               second_chosen,
    output logic                               zero_den_error
);
    frm_pkg::ctrl_t   ctrl;
    frm_pkg::status_t status;

    frm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .status(status), .ctrl(ctrl)
    );

    frm_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .clk(clk), .ctrl(ctrl), .status(status),
        .num_first(num_first), .den_first(den_first),
        .num_second(num_second), .den_second(den_second),
        .max_num(max_num), .max_den(max_den),
        .second_chosen(second_chosen), .zero_den_error(zero_den_error)
    );

    // Never accept while a result is offered
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    // An error result is all zero
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_den_error) |-> (max_den == '0 && !second_chosen))
        else $error("error result not cleared");

    // Valid results carry a nonzero denominator
    a_den: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !zero_den_error) |-> (max_den != '0))
        else $error("zero denominator in result");
endmodule
`default_nettype wire

### verif/fraction_reduce_and_max_tb.sv
// Testbench for fraction_reduce_and_max: random and directed fraction pairs checked by a scoreboard.
`default_nettype none
module fraction_reduce_and_max_tb;

    localparam int W = frm_pkg::VALUE_WIDTH_DEF;
    localparam int N_RANDOM = 1250;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic signed [W-1:0] num;
        logic [W-2:0]        den;
        logic                second;
        logic                zero_err;
    } max_frac_t;

    int error_count = 0;

    // Print one mismatch line and count it
    task automatic report(input string what);
        $display("ERROR %s", what);
        error_count++;
    endtask

    function automatic longint unsigned gcd64(input longint unsigned a, input longint unsigned b);
        longint unsigned r;
        while (b != 0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // Reduce a fraction so that the denominator is positive
    function automatic void reduce_frac(inout longint n, inout longint d);
        longint unsigned an;
        longint unsigned ad;
        longint g;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        g = gcd64(an, ad);
        n = n / g;
        d = d / g;
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
    endfunction

    // Compute the larger reduced fraction of the pair
    function automatic max_frac_t pick_max(input logic signed [W-1:0] n1i,
        input logic signed [W-1:0] d1i, input logic signed [W-1:0] n2i,
        input logic signed [W-1:0] d2i);
        max_frac_t r;
        longint n1, d1, n2, d2, rn, rd, lim;
        logic sec;
        r = '{num: '0, den: '0, second: 1'b0, zero_err: 1'b0};
        if (d1i == 0 || d2i == 0)
        begin
            r.zero_err = 1'b1;
            return r;
        end
        n1 = n1i; d1 = d1i; n2 = n2i; d2 = d2i;
        lim = (longint'(1) << (W - 1)) - 1;
        reduce_frac(n1, d1);
        reduce_frac(n2, d2);
        sec = !(n1 * d2 >= d1 * n2);
        rn = sec ? n2 : n1;
        rd = sec ? d2 : d1;
        if (rn > lim) rn = lim;
        if (rn < -lim) rn = -lim;
        if (rd > lim) rd = lim;
        r.num = rn[W-1:0];
        r.den = rd[W-2:0];
        r.second = sec;
        return r;
    endfunction

    class max_scoreboard;
        max_frac_t pending[$];

        function void note_input(logic signed [W-1:0] n1, logic signed [W-1:0] d1,
            logic signed [W-1:0] n2, logic signed [W-1:0] d2);
            pending.push_back(pick_max(n1, d1, n2, d2));
        endfunction

        task check_result(logic signed [W-1:0] n, logic [W-2:0] d, logic s, logic z);
            max_frac_t e;
            if (pending.size() == 0)
            begin
                report("result with no item pending");
                return;
            end
            e = pending.pop_front();
            if (n !== e.num)
                report($sformatf("max_num %0d exp %0d", n, e.num));
            if (d !== e.den)
                report($sformatf("max_den %0d exp %0d", d, e.den));
            if (s !== e.second)
                report($sformatf("second_chosen %0b exp %0b", s, e.second));
            if (z !== e.zero_err)
                report($sformatf("zero_den_error %0b exp %0b", z, e.zero_err));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [W-1:0] num_first = '0;
    logic signed [W-1:0] den_first = '0;
    logic signed [W-1:0] num_second = '0;
    logic signed [W-1:0] den_second = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [W-1:0] max_num;
    logic [W-2:0] max_den;
    logic second_chosen;
    logic zero_den_error;

    max_scoreboard fractions = new();
    bit calm = 1'b0;
    longint cycle_count = 0;

    fraction_reduce_and_max i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .num_first(num_first), .den_first(den_first),
        .num_second(num_second), .den_second(den_second),
        .out_valid(out_valid), .out_ready(out_ready),
        .max_num(max_num), .max_den(max_den),
        .second_chosen(second_chosen), .zero_den_error(zero_den_error)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Stop the run on timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("fraction_reduce_and_max: mismatch");
            $finish;
        end
    end

    // Check each delivered result; stall the receiver at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                fractions.check_result(max_num, max_den, second_chosen, zero_den_error);
            out_ready <= calm || ($urandom_range(0, 99) >= 24);
        end
    end

    function automatic logic signed [W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 20) - 10;
            1: return $urandom_range(0, 2000) - 1000;
            2: return {1'b1, {(W - 1){1'b0}}};
            3: return {1'b0, {(W - 1){1'b1}}};
            4: return $signed($urandom()) & 32'h0000_ffff;
            5: return -($urandom_range(1, 1 << 16) * 6);
            default: return $urandom();
        endcase
    endfunction

    // Offer one item and hold it until accepted; idle cycles drop valid
    task automatic send_item(input logic signed [W-1:0] n1, input logic signed [W-1:0] d1,
        input logic signed [W-1:0] n2, input logic signed [W-1:0] d2);
        while (!calm && $urandom_range(0, 99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        num_first <= n1;
        den_first <= d1;
        num_second <= n2;
        den_second <= d2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        fractions.note_input(n1, d1, n2, d2);
    endtask

    // Drop valid and wait for every pending result
    task automatic drain();
        in_valid <= 1'b0;
        while (fractions.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic signed [W-1:0] mx;
        logic signed [W-1:0] mn;
        logic signed [W-1:0] d1;
        logic signed [W-1:0] d2;
        int wait_cycles;
        mx = {1'b0, {(W - 1){1'b1}}};
        mn = {1'b1, {(W - 1){1'b0}}};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, ties, zero numerators, zero denominators
        send_item(1, 2, 2, 4);
        send_item(1, 3, 1, 2);
        send_item(-3, -6, 2, -4);
        send_item(0, -5, 0, 7);
        send_item(0, 3, -1, 3);
        send_item(5, 0, 1, 1);
        send_item(1, 1, 5, 0);
        send_item(0, 0, 0, 0);
        send_item(mx, 1, mx, mx);
        send_item(mn, 1, mx, 1);
        send_item(1, mn, -1, mx);
        send_item(mn, -1, 1, 1);
        send_item(mn, mn, 1, 1);
        send_item(1, mn, 0, 1);
        send_item(mx, mn, mn, mx);
        send_item(-1, -1, -1, -1);
        send_item(mx, mx - 1, mx - 1, mx - 2);
        send_item(-7, 21, -1, 3);
        send_item(12, -18, 6, 9);
        send_item(mn, 2, mn, 4);
        send_item(-1, -1, 32'hffff_ffff, 32'h5555_5555);

        // Random, with a quiet stretch and a full drain midway
        for (int i = 0; i < N_RANDOM; i++)
        begin
            calm = (i >= 400 && i < 550);
            if (i == 700)
                drain();
            d1 = pick_value();
            d2 = pick_value();
            if ($urandom_range(0, 99) >= 3 && d1 == 0) d1 = 1;
            if ($urandom_range(0, 99) >= 3 && d2 == 0) d2 = -1;
            if ($urandom_range(0, 99) < 2) d1 = 0;
            send_item(pick_value(), d1, pick_value(), d2);
        end
        calm = 1'b0;

        drain();
        wait_cycles = 0;
        while (wait_cycles < 400)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (error_count == 0 && fractions.pending.size() == 0)
            $display("fraction_reduce_and_max: match");
        else
            $display("fraction_reduce_and_max: mismatch");
        $finish;
    end

endmodule
`default_nettype wire

### files.f
sv/frm_pkg.sv
sv/frm_datapath.sv
sv/frm_ctrl.sv
sv/fraction_reduce_and_max.sv
verif/fraction_reduce_and_max_tb.sv
